/* rtl/dtpc_pkg.sv */
package dtpc_pkg;

  localparam int unsigned CfgAddrW = 5;

  localparam logic [2:0] REG_MAX_DEPTH   = 3'd0;
  localparam logic [2:0] REG_CENTER_X    = 3'd1;
  localparam logic [2:0] REG_CENTER_Y    = 3'd2;
  localparam logic [2:0] REG_INV_FOCAL_X = 3'd3;
  localparam logic [2:0] REG_INV_FOCAL_Y = 3'd4;
  localparam logic [2:0] REG_STRIDE_LOG2 = 3'd5;
  localparam logic [2:0] REG_FRAME_WIDTH = 3'd6;

  localparam logic [19:0] RST_MAX_DEPTH   = 20'd39322;
  localparam logic [19:0] RST_CENTER_X    = 20'd240448;
  localparam logic [19:0] RST_CENTER_Y    = 20'd135384;
  localparam logic [31:0] RST_INV_FOCAL_X = 32'd3370214;
  localparam logic [31:0] RST_INV_FOCAL_Y = 32'd3279461;
  localparam logic [1:0]  RST_STRIDE_LOG2 = 2'd1;
  localparam logic [12:0] RST_FRAME_WIDTH = 13'd896;

  typedef struct packed {
    logic [19:0] max_depth;
    logic [19:0] center_x;
    logic [19:0] center_y;
    logic [31:0] inv_focal_x;
    logic [31:0] inv_focal_y;
    logic [1:0]  stride_log2;
    logic [12:0] frame_width;
  } cfg_t;

  typedef struct packed {
    logic [11:0] pixel_row;
    logic [11:0] pixel_col;
    logic [19:0] depth;
  } in_t;

  typedef struct packed {
    logic [23:0]        point_index;
    logic signed [23:0] x_pos;
    logic signed [23:0] y_pos;
    logic [19:0]        z_pos;
    logic               point_valid;
  } out_t;

  typedef struct packed {
    logic strobe;
    logic point_valid;
  } meta_t;

endpackage

/* rtl/dtpc_cfg_regs.sv */
module dtpc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dtpc_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output dtpc_pkg::cfg_t                cfg
);

  dtpc_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [2:0]     reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[4:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_depth   <= dtpc_pkg::RST_MAX_DEPTH;
      cfg_r.center_x    <= dtpc_pkg::RST_CENTER_X;
      cfg_r.center_y    <= dtpc_pkg::RST_CENTER_Y;
      cfg_r.inv_focal_x <= dtpc_pkg::RST_INV_FOCAL_X;
      cfg_r.inv_focal_y <= dtpc_pkg::RST_INV_FOCAL_Y;
      cfg_r.stride_log2 <= dtpc_pkg::RST_STRIDE_LOG2;
      cfg_r.frame_width <= dtpc_pkg::RST_FRAME_WIDTH;
    end else if (wr_en) begin
      unique case (reg_sel)
        dtpc_pkg::REG_MAX_DEPTH:   cfg_r.max_depth   <= pwdata[19:0];
        dtpc_pkg::REG_CENTER_X:    cfg_r.center_x    <= pwdata[19:0];
        dtpc_pkg::REG_CENTER_Y:    cfg_r.center_y    <= pwdata[19:0];
        dtpc_pkg::REG_INV_FOCAL_X: cfg_r.inv_focal_x <= pwdata;
        dtpc_pkg::REG_INV_FOCAL_Y: cfg_r.inv_focal_y <= pwdata;
        dtpc_pkg::REG_STRIDE_LOG2: cfg_r.stride_log2 <= pwdata[1:0];
        dtpc_pkg::REG_FRAME_WIDTH: cfg_r.frame_width <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      dtpc_pkg::REG_MAX_DEPTH:   prdata = {12'd0, cfg_r.max_depth};
      dtpc_pkg::REG_CENTER_X:    prdata = {12'd0, cfg_r.center_x};
      dtpc_pkg::REG_CENTER_Y:    prdata = {12'd0, cfg_r.center_y};
      dtpc_pkg::REG_INV_FOCAL_X: prdata = cfg_r.inv_focal_x;
      dtpc_pkg::REG_INV_FOCAL_Y: prdata = cfg_r.inv_focal_y;
      dtpc_pkg::REG_STRIDE_LOG2: prdata = {30'd0, cfg_r.stride_log2};
      dtpc_pkg::REG_FRAME_WIDTH: prdata = {19'd0, cfg_r.frame_width};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/dtpc_axis_lane.sv */
module dtpc_axis_lane (
  input  logic               clk,
  input  logic [11:0]        pix,
  input  logic [19:0]        depth,
  input  logic               depth_ok,
  input  logic [19:0]        center,
  input  logic [31:0]        inv_focal,
  output logic signed [23:0] coord
);

  // stage 1: pixel offset magnitude and sign
  logic [20:0] diff;
  logic        neg_nxt;
  logic [20:0] mag_nxt;
  logic [20:0] mag_r;
  logic        neg1_r;
  logic [19:0] z1_r;
  logic        ok1_r;

  // stage 2: offset times depth
  logic [40:0] m_r;
  logic        neg2_r;
  logic        ok2_r;

  // stage 3: split product with reciprocal focal length
  logic [63:0] lo_r;
  logic [40:0] hi_r;
  logic        neg3_r;
  logic        ok3_r;

  // stage 4: round, saturate, sign
  logic [41:0]        sum;
  logic [42:0]        rnd;
  logic [34:0]        q;
  logic signed [23:0] coord_nxt;
  logic signed [23:0] coord_r;

  assign diff    = {1'b0, pix, 8'h00} - {1'b0, center};
  assign neg_nxt = diff[20];
  assign mag_nxt = neg_nxt ? (21'd0 - diff) : diff;

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    neg1_r <= neg_nxt;
    z1_r   <= depth;
    ok1_r  <= depth_ok;

    m_r    <= 41'(mag_r) * 41'(z1_r);
    neg2_r <= neg1_r;
    ok2_r  <= ok1_r;

    lo_r   <= 64'(m_r[31:0]) * 64'(inv_focal);
    hi_r   <= 41'(m_r[40:32]) * 41'(inv_focal);
    neg3_r <= neg2_r;
    ok3_r  <= ok2_r;

    coord_r <= coord_nxt;
  end

  assign sum = {1'b0, hi_r} + {10'd0, lo_r[63:32]};
  assign rnd = {1'b0, sum} + 43'd128;
  assign q   = rnd[42:8];

  always_comb begin
    if (!ok3_r) begin
      coord_nxt = 24'sd0;
    end else if (neg3_r) begin
      if (q > 35'd8388608) begin
        coord_nxt = 24'sh800000;
      end else begin
        coord_nxt = 24'(35'd0 - q);
      end
    end else begin
      if (q > 35'd8388607) begin
        coord_nxt = 24'sh7FFFFF;
      end else begin
        coord_nxt = 24'(q);
      end
    end
  end

  assign coord = coord_r;

endmodule

/* rtl/dtpc_index.sv */
module dtpc_index #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [11:0]         pixel_row,
  input  logic [11:0]         pixel_col,
  input  logic [19:0]         depth,
  input  logic                depth_ok,
  input  logic [1:0]          stride_log2,
  input  logic [12:0]         frame_width,
  output logic [23:0]         point_index,
  output logic [19:0]         z_pos,
  output dtpc_pkg::meta_t     meta
);

  localparam logic [12:0] MaxW = 13'(MAX_WIDTH);
  localparam logic [12:0] MaxH = 13'(MAX_HEIGHT);

  logic [2:0]  smask;
  logic        in_range;
  logic        aligned;
  logic        v1_nxt;
  logic [12:0] fw_clamp;

  logic        v1_r, v2_r, v3_r, v4_r;
  logic        ok1_r, ok2_r, ok3_r, ok4_r;
  logic [19:0] z1_r, z2_r, z3_r, z4_r;
  logic [11:0] rs_r;
  logic [12:0] fs_r;
  logic [11:0] cs1_r, cs2_r;
  logic [24:0] prod_r;
  logic [23:0] idx3_r, idx4_r;

  assign smask    = 3'((4'd1 << stride_log2) - 4'd1);
  assign in_range = ({1'b0, pixel_row} < MaxH) && ({1'b0, pixel_col} < MaxW);
  assign aligned  = ((pixel_row[2:0] & smask) == 3'd0) && ((pixel_col[2:0] & smask) == 3'd0);
  assign v1_nxt   = accept && in_range && aligned;
  assign fw_clamp = (frame_width > MaxW) ? MaxW : frame_width;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    rs_r   <= pixel_row >> stride_log2;
    fs_r   <= fw_clamp >> stride_log2;
    cs1_r  <= pixel_col >> stride_log2;
    z1_r   <= depth;
    ok1_r  <= depth_ok;

    prod_r <= 25'(rs_r) * 25'(fs_r);
    cs2_r  <= cs1_r;
    z2_r   <= z1_r;
    ok2_r  <= ok1_r;

    idx3_r <= 24'(prod_r + 25'(cs2_r));
    z3_r   <= z2_r;
    ok3_r  <= ok2_r;

    idx4_r <= idx3_r;
    z4_r   <= ok3_r ? z3_r : 20'd0;
    ok4_r  <= ok3_r;
  end

  assign point_index      = idx4_r;
  assign z_pos            = z4_r;
  assign meta.strobe      = v4_r;
  assign meta.point_valid = ok4_r;

endmodule

/* rtl/depth_to_point_cloud_unit.sv */
// Depth pixel to 3D point back-projection, four register stages.
// A result strobes on out_valid once a taken start has passed through the four register stages.
// Throughput: one pixel per cycle; busy is always low, the receiver cannot stall.
// Unsampled or out-of-range pixels give no result beat.
// Reset (rst_n low, synchronous) clears the pipeline valids and loads register defaults.
module depth_to_point_cloud_unit #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  dtpc_pkg::in_t                 in_data,
  output logic                          out_valid,
  output dtpc_pkg::out_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dtpc_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  dtpc_pkg::cfg_t  cfg;
  dtpc_pkg::meta_t meta;
  logic            accept;
  logic            depth_ok;
  logic signed [23:0] x_pos;
  logic signed [23:0] y_pos;
  logic [23:0]     point_index;
  logic [19:0]     z_pos;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign depth_ok = (in_data.depth != 20'd0) && (in_data.depth <= cfg.max_depth);

  dtpc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dtpc_index #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_index (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .pixel_row   (in_data.pixel_row),
    .pixel_col   (in_data.pixel_col),
    .depth       (in_data.depth),
    .depth_ok    (depth_ok),
    .stride_log2 (cfg.stride_log2),
    .frame_width (cfg.frame_width),
    .point_index (point_index),
    .z_pos       (z_pos),
    .meta        (meta)
  );

  dtpc_axis_lane u_lane_x (
    .clk       (clk),
    .pix       (in_data.pixel_col),
    .depth     (in_data.depth),
    .depth_ok  (depth_ok),
    .center    (cfg.center_x),
    .inv_focal (cfg.inv_focal_x),
    .coord     (x_pos)
  );

  dtpc_axis_lane u_lane_y (
    .clk       (clk),
    .pix       (in_data.pixel_row),
    .depth     (in_data.depth),
    .depth_ok  (depth_ok),
    .center    (cfg.center_y),
    .inv_focal (cfg.inv_focal_y),
    .coord     (y_pos)
  );

  assign out_valid            = meta.strobe;
  assign out_data.point_index = point_index;
  assign out_data.x_pos       = x_pos;
  assign out_data.y_pos       = y_pos;
  assign out_data.z_pos       = z_pos;
  assign out_data.point_valid = meta.point_valid;

endmodule

/* tb/sv/dtpc_point_checker.sv */
`timescale 1ns / 100ps

module dtpc_point_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  dtpc_pkg::in_t                 in_data,
  input  logic                          out_valid,
  input  dtpc_pkg::out_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dtpc_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  input  logic                          pready,
  output int                            mismatches,
  output int                            points_owed,
  output int                            points_checked
);
  import dtpc_pkg::*;

  localparam int unsigned MAX_WIDTH = 4096;

  cfg_t settings;
  out_t pending_points[$];
  out_t want;
  out_t beat;

  // (pix - center) * z * inv_f, rounded half away from zero, saturated to 24 bits
  function automatic logic [23:0] axis_coord(input logic [11:0] pix, input logic [19:0] center,
                                              input logic [19:0] z, input logic [31:0] inv_f);
    logic [21:0] offset;
    logic        neg;
    logic [20:0] mag;
    logic [72:0] prod;
    logic [72:0] q;
    offset = {2'b00, pix, 8'h00} - {2'b00, center};
    neg = offset[21];
    mag = neg ? 21'(-offset) : offset[20:0];
    prod = {52'd0, mag} * {53'd0, z} * {41'd0, inv_f};
    q = ((prod >> 32) + 73'd128) >> 8;
    if (neg) begin
      return (q > 73'd8388608) ? 24'h800000 : 24'(-q);
    end
    return (q > 73'd8388607) ? 24'h7FFFFF : q[23:0];
  endfunction

  function automatic bit back_project(input in_t px, input cfg_t c, output out_t pt);
    logic [11:0] smask;
    logic [12:0] fw;
    logic [31:0] idx;
    smask = 12'((1 << c.stride_log2) - 1);
    pt = '0;
    if (((px.pixel_row | px.pixel_col) & smask) != 12'd0) return 1'b0;
    fw = (c.frame_width > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : c.frame_width;
    idx = ({20'd0, px.pixel_row} >> c.stride_log2) * ({19'd0, fw} >> c.stride_log2)
        + ({20'd0, px.pixel_col} >> c.stride_log2);
    pt.point_index = idx[23:0];
    if (px.depth == 20'd0 || px.depth > c.max_depth) return 1'b1;
    pt.x_pos = axis_coord(px.pixel_col, c.center_x, px.depth, c.inv_focal_x);
    pt.y_pos = axis_coord(px.pixel_row, c.center_y, px.depth, c.inv_focal_y);
    pt.z_pos = px.depth;
    pt.point_valid = 1'b1;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      settings <= '{RST_MAX_DEPTH, RST_CENTER_X, RST_CENTER_Y, RST_INV_FOCAL_X,
                    RST_INV_FOCAL_Y, RST_STRIDE_LOG2, RST_FRAME_WIDTH};
      pending_points.delete();
    end else begin
      if (out_valid) begin
        beat = out_data;
        points_checked++;
        if (pending_points.size() == 0) begin
          $error("unexpected point beat, point_index %0d", beat.point_index);
          mismatches++;
        end else begin
          want = pending_points.pop_front();
          if (beat.point_index !== want.point_index) begin
            $error("point_index: expected %0d, got %0d", want.point_index, beat.point_index);
            mismatches++;
          end
          if (beat.x_pos !== want.x_pos) begin
            $error("x_pos: expected %0d, got %0d", $signed(want.x_pos), $signed(beat.x_pos));
            mismatches++;
          end
          if (beat.y_pos !== want.y_pos) begin
            $error("y_pos: expected %0d, got %0d", $signed(want.y_pos), $signed(beat.y_pos));
            mismatches++;
          end
          if (beat.z_pos !== want.z_pos) begin
            $error("z_pos: expected %0d, got %0d", want.z_pos, beat.z_pos);
            mismatches++;
          end
          if (beat.point_valid !== want.point_valid) begin
            $error("point_valid: expected %0d, got %0d", want.point_valid, beat.point_valid);
            mismatches++;
          end
        end
      end
      if (start && !busy && back_project(in_data, settings, want)) begin
        pending_points = {pending_points, want};
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_MAX_DEPTH:   settings.max_depth   <= pwdata[19:0];
          REG_CENTER_X:    settings.center_x    <= pwdata[19:0];
          REG_CENTER_Y:    settings.center_y    <= pwdata[19:0];
          REG_INV_FOCAL_X: settings.inv_focal_x <= pwdata;
          REG_INV_FOCAL_Y: settings.inv_focal_y <= pwdata;
          REG_STRIDE_LOG2: settings.stride_log2 <= pwdata[1:0];
          REG_FRAME_WIDTH: settings.frame_width <= pwdata[12:0];
          default: ;
        endcase
      end
    end
    points_owed = pending_points.size();
  end

endmodule

/* tb/sv/depth_to_point_cloud_unit_tb.sv */
`timescale 1ns / 100ps

module depth_to_point_cloud_unit_tb;
  import dtpc_pkg::*;

  localparam int DRAIN_CYCLES     = 8;
  localparam int IDLE_LIMIT       = 4000;
  localparam int RANDOM_PHASES    = 8;
  localparam int POINTS_PER_PHASE = 45;

  localparam cfg_t DEFAULT_SETTINGS = '{RST_MAX_DEPTH, RST_CENTER_X, RST_CENTER_Y,
                                        RST_INV_FOCAL_X, RST_INV_FOCAL_Y,
                                        RST_STRIDE_LOG2, RST_FRAME_WIDTH};

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  in_t                 in_data;
  logic                out_valid;
  out_t                out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  int mismatches;
  int points_owed;
  int points_checked;
  int idle_cycles;
  int pixels_sent;
  int settings_used;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  depth_to_point_cloud_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  dtpc_point_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .mismatches    (mismatches),
    .points_owed   (points_owed),
    .points_checked(points_checked)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("depth_to_point_cloud_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_pixel(input logic [11:0] row, input logic [11:0] col,
                            input logic [19:0] depth);
    @(negedge clk);
    start   <= 1'b1;
    in_data <= '{row, col, depth};
    @(posedge clk);
    while (busy) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // pixels off the sampling grid give no beat, so give the pipe time to empty
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (points_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_settings(input cfg_t c);
    drain();
    write_reg(REG_MAX_DEPTH,   32'(c.max_depth));
    write_reg(REG_CENTER_X,    32'(c.center_x));
    write_reg(REG_CENTER_Y,    32'(c.center_y));
    write_reg(REG_INV_FOCAL_X, c.inv_focal_x);
    write_reg(REG_INV_FOCAL_Y, c.inv_focal_y);
    write_reg(REG_STRIDE_LOG2, 32'(c.stride_log2));
    write_reg(REG_FRAME_WIDTH, 32'(c.frame_width));
    settings_used++;
  endtask

  function automatic logic [31:0] pick_inv_focal();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(1_000_000, 20_000_000);
    endcase
  endfunction

  function automatic logic [19:0] pick_center();
    case ($urandom_range(0, 4))
      0:       return 20'd0;
      1:       return 20'hFFFFF;
      default: return 20'($urandom_range(0, 20'hFFFFF));
    endcase
  endfunction

  function automatic cfg_t pick_settings();
    cfg_t c;
    case ($urandom_range(0, 7))
      0:       c.max_depth = 20'hFFFFF;
      1:       c.max_depth = 20'd0;
      2, 3:    c.max_depth = 20'($urandom_range(0, 20'hFFFFF));
      default: c.max_depth = 20'($urandom_range(1000, 200000));
    endcase
    c.center_x    = pick_center();
    c.center_y    = pick_center();
    c.inv_focal_x = pick_inv_focal();
    c.inv_focal_y = pick_inv_focal();
    c.stride_log2 = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0:       c.frame_width = 13'd0;
      1:       c.frame_width = 13'h1FFF;
      2:       c.frame_width = 13'd4096;
      default: c.frame_width = 13'($urandom_range(1, 4096));
    endcase
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [11:0] pick_coord(input logic [11:0] smask, input bit on_grid);
    logic [11:0] v;
    case ($urandom_range(0, 7))
      0:       v = 12'd0;
      1:       v = 12'hFFF;
      default: v = 12'($urandom_range(0, 4095));
    endcase
    return on_grid ? (v & ~smask) : v;
  endfunction

  initial begin
    cfg_t        c;
    logic [11:0] smask;
    logic [11:0] row;
    logic [11:0] col;
    logic [19:0] depth;
    bit          on_grid;
    bit          steady;
    int          points;

    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    pixels_sent = 0;
    settings_used = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // power-on settings: depth limits, off-grid pixels, frame corners
    send_pixel(12'd0, 12'd0, 20'd1);
    send_pixel(12'd0, 12'd0, 20'd0);
    send_pixel(12'd2, 12'd2, RST_MAX_DEPTH);
    send_pixel(12'd2, 12'd4, RST_MAX_DEPTH + 20'd1);
    send_pixel(12'd4094, 12'd4094, RST_MAX_DEPTH);
    send_pixel(12'd1, 12'd0, 20'd100);
    hold_off(2);
    send_pixel(12'd0, 12'd1, 20'd100);
    send_pixel(12'd4095, 12'd4095, 20'hFFFFF);
    send_pixel(12'd0, 12'd4094, 20'hFFFFF);
    send_pixel(12'd4094, 12'd0, 20'd20000);

    // full-scale focal gains: saturation both ways, clamped frame width, largest index
    load_settings('{20'hFFFFF, 20'd0, 20'hFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    2'd0, 13'h1FFF});
    send_pixel(12'd4095, 12'd4095, 20'hFFFFF);
    send_pixel(12'd0, 12'd0, 20'hFFFFF);
    send_pixel(12'd0, 12'd4095, 20'hFFFFF);
    send_pixel(12'd4095, 12'd0, 20'd1);
    send_pixel(12'd0, 12'd0, 20'd0);

    // zero depth limit, zero focal gain, widest stride, zero frame width
    load_settings('{20'd0, 20'hFFFFF, 20'd0, 32'd0, 32'd1, 2'd3, 13'd0});
    send_pixel(12'd0, 12'd0, 20'd0);
    send_pixel(12'd0, 12'd0, 20'd1);
    send_pixel(12'd8, 12'd8, 20'd5);
    send_pixel(12'd4088, 12'd4088, 20'hFFFFF);
    send_pixel(12'd4, 12'd8, 20'd1);

    load_settings('{20'hFFFFF, 20'h80000, 20'h80000, 32'd0, 32'd1, 2'd2, 13'd1});
    send_pixel(12'd4092, 12'd4092, 20'hFFFFF);
    send_pixel(12'd4, 12'd8, 20'd12345);
    send_pixel(12'd2, 12'd8, 20'd12345);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      c = (phase == 0) ? DEFAULT_SETTINGS : pick_settings();
      load_settings(c);
      smask  = 12'((1 << c.stride_log2) - 1);
      steady = ($urandom_range(0, 3) == 0);
      points = 0;
      while (points < POINTS_PER_PHASE) begin
        on_grid = ($urandom_range(0, 9) != 0);
        row = pick_coord(smask, on_grid);
        col = pick_coord(smask, on_grid);
        case ($urandom_range(0, 9))
          0: depth = 20'd0;
          1: depth = 20'($urandom_range(0, 20'hFFFFF));
          2: depth = c.max_depth;
          3: depth = (c.max_depth == 20'hFFFFF) ? 20'hFFFFF :
                     20'($urandom_range(c.max_depth + 1, 20'hFFFFF));
          default: depth = (c.max_depth == 20'd0) ? 20'd0 :
                           20'($urandom_range(1, c.max_depth));
        endcase
        send_pixel(row, col, depth);
        if (((row | col) & smask) == 12'd0) points++;
        if ($urandom_range(0, 63) == 0) drain();
        else if (!steady) hold_off(pick_gap());
      end
    end

    drain();
    $display("%0d pixels sent under %0d register settings, %0d point beats checked",
             pixels_sent, settings_used, points_checked);
    if (mismatches == 0 && points_owed == 0) begin
      $display("depth_to_point_cloud_unit regression: pass");
    end else begin
      $display("depth_to_point_cloud_unit regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/dtpc_pkg.sv
rtl/dtpc_cfg_regs.sv
rtl/dtpc_axis_lane.sv
rtl/dtpc_index.sv
rtl/depth_to_point_cloud_unit.sv
tb/sv/dtpc_point_checker.sv
tb/sv/depth_to_point_cloud_unit_tb.sv
